### src/assert_macros.svh
// Assertion macros for the files that check their own logic.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, prop)

`define ASSERT_NEVER(lbl, expr)

`endif

`endif

### src/tlbbt_pkg.sv
package tlbbt_pkg;

  localparam int MASK_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int BLOCK_W    = 13;
  localparam int FOUND_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int MAX_LEAVES = (2 ** BLOCK_W) / MASK_BITS;

  typedef enum logic [1:0] {
    CMD_MARK    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_FIND    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load_in;
    logic look;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic               is_marked;
    logic [FOUND_W-1:0] found_block;
    logic               found_valid;
    logic               status;
    logic [COUNT_W-1:0] marked_count;
  } out_word_t;

endpackage

### src/tlbbt_if.sv
interface tlbbt_in_if import tlbbt_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_t               command;
  logic [BLOCK_W-1:0] block_index;

  modport source (output valid, output command, output block_index, input ready);
  modport sink (input valid, input command, input block_index, output ready);
endinterface

interface tlbbt_out_if import tlbbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_marked;
  logic [FOUND_W-1:0] found_block;
  logic               found_valid;
  logic               status;
  logic [COUNT_W-1:0] marked_count;

  modport source (
    output valid, output is_marked, output found_block, output found_valid,
    output status, output marked_count, input ready
  );
  modport sink (
    input valid, input is_marked, input found_block, input found_valid,
    input status, input marked_count, output ready
  );
endinterface

### src/tlbbt_ctrl.sv
module tlbbt_ctrl import tlbbt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.load_in = in_valid && (state_r == S_IDLE);
  assign cmd.look    = (state_r == S_LOOK);
  assign cmd.exec    = (state_r == S_EXEC) && !stat.out_busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/tlbbt_dp.sv
module tlbbt_dp import tlbbt_pkg::*; #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  input  cmd_t               in_command,
  input  logic [BLOCK_W-1:0] in_block_index,
  input  logic               out_ready,
  output logic               out_valid,
  output out_word_t          out_word
);

  localparam int LEAF_COUNT = (NUM_BLOCKS + MASK_BITS - 1) / MASK_BITS;
  localparam int ELEAF      = (LEAF_COUNT > MAX_LEAVES) ? MAX_LEAVES : LEAF_COUNT;
  localparam int LW         = (ELEAF > 1) ? $clog2(ELEAF) : 1;
  localparam int REM        = NUM_BLOCKS % MASK_BITS;
  localparam bit HAS_OVF    = (LEAF_COUNT > MAX_LEAVES);
  localparam bit LAST_PART  = (REM != 0) && !HAS_OVF;
  localparam logic [LW-1:0] LAST_LEAF = LW'(ELEAF - 1);
  localparam logic [MASK_BITS-1:0] LAST_PATTERN =
    (REM == 0) ? '1 : ((MASK_BITS'(1) << REM) - MASK_BITS'(1));
  localparam logic [FOUND_W-1:0] OVF_BLOCK = FOUND_W'(ELEAF * MASK_BITS);

  logic [MASK_BITS-1:0] mem [ELEAF];

  cmd_t                 cmd_r;
  logic [BLOCK_W-1:0]   idx_r;
  logic [LW-1:0]        leaf_r;
  logic                 open_any_r;
  logic [MASK_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  logic [ELEAF-1:0]     summary_r, summary_nxt;
  logic [ELEAF-1:0]     leaf_vld_r, leaf_vld_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_r, out_nxt;

  logic [LW-1:0]        enc;
  logic                 any_open;
  logic [LW-1:0]        rd_addr;
  logic [MASK_BITS-1:0] leaf_word;
  logic [MASK_BITS-1:0] bit_mask;
  logic [MASK_BITS-1:0] pattern;
  logic [MASK_BITS-1:0] free_bits;
  logic [MASK_BITS-1:0] wr_word;
  logic [BIT_W-1:0]     free_pos;
  logic                 was;
  logic                 range_err;
  logic                 wr_en;

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_word      = out_r;

  // The lowest leaf that is not full, taken from the summary bits.
  always_comb begin
    enc      = '0;
    any_open = 1'b0;
    for (int i = ELEAF - 1; i >= 0; i--) begin
      if (!summary_r[i]) begin
        enc      = LW'(i);
        any_open = 1'b1;
      end
    end
  end

  assign rd_addr = (cmd_r == CMD_FIND) ? enc : idx_r[LW+BIT_W-1:BIT_W];

  assign leaf_word = rd_vld_r ? rd_data_r : '0;
  assign bit_mask  = MASK_BITS'(1) << idx_r[BIT_W-1:0];
  assign was       = |(leaf_word & bit_mask);
  assign pattern   = (LAST_PART && (leaf_r == LAST_LEAF)) ? LAST_PATTERN : '1;
  assign free_bits = ~leaf_word & pattern;
  assign range_err = (32'(idx_r) >= 32'(NUM_BLOCKS));

  always_comb begin
    free_pos = '0;
    for (int i = MASK_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_pos = BIT_W'(i);
      end
    end
  end

  always_comb begin
    summary_nxt   = summary_r;
    leaf_vld_nxt  = leaf_vld_r;
    count_nxt     = count_r;
    wr_en         = 1'b0;
    wr_word       = leaf_word;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.exec) begin
      out_nxt = '0;
      if (cmd_r == CMD_FIND) begin
        if (open_any_r) begin
          out_nxt.found_valid = |free_bits;
          if (|free_bits) begin
            out_nxt.found_block = FOUND_W'({leaf_r, free_pos});
          end
        end else if (HAS_OVF) begin
          out_nxt.found_valid = 1'b1;
          out_nxt.found_block = OVF_BLOCK;
        end
      end else if (range_err) begin
        out_nxt.status = 1'b1;
      end else begin
        unique case (cmd_r)
          CMD_MARK: begin
            if (!was) begin
              wr_en     = 1'b1;
              wr_word   = leaf_word | bit_mask;
              count_nxt = count_r + COUNT_W'(1);
              if ((leaf_word | bit_mask) == pattern) begin
                summary_nxt[leaf_r] = 1'b1;
              end
            end
          end
          CMD_RELEASE: begin
            if (was) begin
              wr_en     = 1'b1;
              wr_word   = leaf_word & ~bit_mask;
              count_nxt = count_r - COUNT_W'(1);
            end
            summary_nxt[leaf_r] = 1'b0;
          end
          CMD_QUERY: begin
            out_nxt.is_marked = was;
          end
          default: begin
          end
        endcase
      end
      if (wr_en) begin
        leaf_vld_nxt[leaf_r] = 1'b1;
      end
      out_nxt.marked_count = count_nxt;
      out_valid_nxt        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summary_r   <= '0;
      leaf_vld_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      summary_r   <= summary_nxt;
      leaf_vld_r  <= leaf_vld_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.load_in) begin
      cmd_r <= in_command;
      idx_r <= in_block_index;
    end
    if (cmd.look) begin
      leaf_r     <= rd_addr;
      open_any_r <= any_open;
      rd_data_r  <= mem[rd_addr];
      rd_vld_r   <= leaf_vld_r[rd_addr];
    end
    if (wr_en) begin
      mem[leaf_r] <= wr_word;
    end
  end

endmodule

### src/two_level_bitmap_block_tracker_core.sv
// Words are handled one at a time by a read-modify-write of the leaf memory (decode
// or summary search, registered leaf read, then update and result); no new word is
// taken until the result is registered, which waits until the previous result is taken.
// Reset (synchronous, rst_n low): all blocks unmarked, summary and count cleared at once;
// leaf words read as zero until first written, so no clearing pass is needed.
`include "assert_macros.svh"

module two_level_bitmap_block_tracker_core import tlbbt_pkg::*; #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  tlbbt_in_if.sink    in_ch,
  tlbbt_out_if.source out_ch
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;
  out_word_t out_word;
  logic      out_valid;
  logic      in_ready;

  tlbbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  tlbbt_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (ctrl_cmd),
    .stat           (dp_stat),
    .in_command     (in_ch.command),
    .in_block_index (in_ch.block_index),
    .out_ready      (out_ch.ready),
    .out_valid      (out_valid),
    .out_word       (out_word)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.is_marked    = out_word.is_marked;
  assign out_ch.found_block  = out_word.found_block;
  assign out_ch.found_valid  = out_word.found_valid;
  assign out_ch.status       = out_word.status;
  assign out_ch.marked_count = out_word.marked_count;

  `ASSERT_CLK(a_one_in_flight, (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
  `ASSERT_CLK(a_exec_gives_word, ctrl_cmd.exec |=> out_ch.valid)
  `ASSERT_NEVER(a_err_no_result, out_ch.valid && out_ch.status && (out_ch.found_valid || out_ch.is_marked))

endmodule

### test/tlbbt_tracker_monitor.sv
`timescale 1ns / 100ps

module tlbbt_tracker_monitor import tlbbt_pkg::*; #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  tlbbt_in_if  in_mon,
  tlbbt_out_if out_mon,
  output int   fail_count,
  output int   pending
);

  localparam int LEAVES = (NUM_BLOCKS + MASK_BITS - 1) / MASK_BITS;

  logic [MASK_BITS-1:0] leaf_bits [LEAVES];
  logic [LEAVES-1:0]    full_leaves;
  logic [COUNT_W-1:0]   committed;
  out_word_t            expected_q [$];
  int                   mismatches;

  function automatic logic [MASK_BITS-1:0] leaf_pattern(input int leaf);
    int rem;
    rem = NUM_BLOCKS % MASK_BITS;
    if (leaf == LEAVES - 1 && rem != 0) begin
      return (64'd1 << rem) - 64'd1;
    end
    return '1;
  endfunction

  function automatic int lowest_one(input logic [MASK_BITS-1:0] v);
    for (int n = 0; n < MASK_BITS; n++) begin
      if (v[n]) begin
        return n;
      end
    end
    return MASK_BITS - 1;
  endfunction

  function automatic out_word_t track_word(input cmd_t cmd, input logic [BLOCK_W-1:0] idx);
    out_word_t            res;
    int                   leaf;
    int                   pos;
    logic [MASK_BITS-1:0] free_bits;
    logic                 was;
    res = '0;
    if (cmd == CMD_FIND) begin
      leaf = -1;
      for (int l = LEAVES - 1; l >= 0; l--) begin
        if (!full_leaves[l]) begin
          leaf = l;
        end
      end
      if (leaf >= 0) begin
        free_bits = ~leaf_bits[leaf] & leaf_pattern(leaf);
        if (free_bits != '0) begin
          res.found_block = FOUND_W'(leaf * MASK_BITS + lowest_one(free_bits));
          res.found_valid = 1'b1;
        end
      end
    end else if (int'(idx) >= NUM_BLOCKS) begin
      res.status = 1'b1;
    end else begin
      leaf = int'(idx) / MASK_BITS;
      pos  = int'(idx) % MASK_BITS;
      was  = leaf_bits[leaf][pos];
      case (cmd)
        CMD_MARK: begin
          if (!was) begin
            leaf_bits[leaf][pos] = 1'b1;
            committed = committed + 1'b1;
            if (leaf_bits[leaf] == leaf_pattern(leaf)) begin
              full_leaves[leaf] = 1'b1;
            end
          end
        end
        CMD_RELEASE: begin
          if (was) begin
            leaf_bits[leaf][pos] = 1'b0;
            committed = committed - 1'b1;
          end
          full_leaves[leaf] = 1'b0;
        end
        default: begin
          res.is_marked = was;
        end
      endcase
    end
    res.marked_count = committed;
    return res;
  endfunction

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      for (int l = 0; l < LEAVES; l++) begin
        leaf_bits[l] = '0;
      end
      full_leaves = '0;
      committed   = '0;
      mismatches  = 0;
      expected_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result word: marked=%0d found=%0d/%0d status=%0d count=%0d",
                     $realtime, out_mon.is_marked, out_mon.found_block, out_mon.found_valid,
                     out_mon.status, out_mon.marked_count);
          end
        end else begin
          exp_w = expected_q.pop_front();
          if (out_mon.is_marked !== exp_w.is_marked ||
              out_mon.found_block !== exp_w.found_block ||
              out_mon.found_valid !== exp_w.found_valid ||
              out_mon.status !== exp_w.status ||
              out_mon.marked_count !== exp_w.marked_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result word differs", $realtime);
              $display("  expected: marked=%0d found=%0d/%0d status=%0d count=%0d",
                       exp_w.is_marked, exp_w.found_block, exp_w.found_valid,
                       exp_w.status, exp_w.marked_count);
              $display("  actual:   marked=%0d found=%0d/%0d status=%0d count=%0d",
                       out_mon.is_marked, out_mon.found_block, out_mon.found_valid,
                       out_mon.status, out_mon.marked_count);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(track_word(in_mon.command, in_mon.block_index));
      end
      fail_count <= mismatches;
      pending    <= expected_q.size();
    end
  end

endmodule

### test/two_level_bitmap_block_tracker_core_tb.sv
`timescale 1ns / 100ps

module two_level_bitmap_block_tracker_core_tb;
  import tlbbt_pkg::*;

  localparam int NUM_BLOCKS   = 4096;
  localparam int LEAVES       = (NUM_BLOCKS + MASK_BITS - 1) / MASK_BITS;
  localparam int MAX_INDEX    = (2 ** BLOCK_W) - 1;
  localparam int RANDOM_WORDS = 1950;
  localparam int IDLE_LIMIT   = 2000;

  logic clk;
  logic rst_n;
  logic burst;
  int   fail_count;
  int   pending;
  int   words_sent;
  int   idle_cycles;
  int   offsets [MASK_BITS];

  tlbbt_in_if  in_ch ();
  tlbbt_out_if out_ch ();

  two_level_bitmap_block_tracker_core #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tlbbt_tracker_monitor #(.NUM_BLOCKS(NUM_BLOCKS)) u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_leaf();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom_range(0, LEAVES - 1);
    end
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [BLOCK_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return BLOCK_W'($urandom_range(NUM_BLOCKS, MAX_INDEX));
    end else if (r < 6) begin
      return BLOCK_W'($urandom_range(0, 4 * MASK_BITS - 1));
    end
    return BLOCK_W'($urandom_range(0, NUM_BLOCKS - 1));
  endfunction

  task automatic shuffle_offsets();
    int j;
    int t;
    for (int i = 0; i < MASK_BITS; i++) begin
      offsets[i] = i;
    end
    for (int i = MASK_BITS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = offsets[i];
      offsets[i] = offsets[j];
      offsets[j] = t;
    end
  endtask

  task automatic send_word(input cmd_t cmd, input logic [BLOCK_W-1:0] idx);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.block_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  initial begin
    int hi_run;
    int lo_run;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      hi_run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1, 2: lo_run = 0;
        9:       lo_run = $urandom_range(15, 60);
        default: lo_run = $urandom_range(1, 4);
      endcase
      out_ch.ready <= 1'b1;
      repeat (hi_run) @(posedge clk);
      if (lo_run != 0) begin
        out_ch.ready <= 1'b0;
        repeat (lo_run) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int start;
    int leaf;
    rst_n             = 1'b0;
    burst             = 1'b0;
    words_sent        = 0;
    idle_cycles       = 0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_MARK;
    in_ch.block_index = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_word(CMD_FIND, '0);
    send_word(CMD_QUERY, '0);
    send_word(CMD_MARK, '0);
    send_word(CMD_MARK, '0);
    send_word(CMD_QUERY, '0);
    send_word(CMD_FIND, '0);
    send_word(CMD_RELEASE, '0);
    send_word(CMD_RELEASE, '0);
    send_word(CMD_QUERY, '0);
    send_word(CMD_MARK, BLOCK_W'(NUM_BLOCKS - 1));
    send_word(CMD_QUERY, BLOCK_W'(NUM_BLOCKS - 1));
    send_word(CMD_FIND, BLOCK_W'(MAX_INDEX));
    send_word(CMD_MARK, BLOCK_W'(NUM_BLOCKS));
    send_word(CMD_RELEASE, BLOCK_W'(MAX_INDEX));
    send_word(CMD_QUERY, BLOCK_W'(MAX_INDEX));
    send_word(CMD_QUERY, BLOCK_W'(NUM_BLOCKS));
    send_word(CMD_MARK, BLOCK_W'(MAX_INDEX));
    send_word(CMD_RELEASE, BLOCK_W'(NUM_BLOCKS - 1));
    send_word(CMD_MARK, BLOCK_W'(1));
    send_word(CMD_MARK, BLOCK_W'(2));
    send_word(CMD_FIND, BLOCK_W'(NUM_BLOCKS));
    send_word(CMD_RELEASE, BLOCK_W'(1));
    send_word(CMD_FIND, '0);

    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          leaf = pick_leaf();
          shuffle_offsets();
          for (int i = 0; i < MASK_BITS; i++) begin
            send_word(CMD_MARK, BLOCK_W'(leaf * MASK_BITS + offsets[i]));
            if ($urandom_range(0, 15) == 0) begin
              send_word(CMD_FIND, BLOCK_W'($urandom_range(0, MAX_INDEX)));
            end
          end
          send_word(CMD_FIND, BLOCK_W'($urandom_range(0, MAX_INDEX)));
          send_word(CMD_QUERY, BLOCK_W'(leaf * MASK_BITS + $urandom_range(0, MASK_BITS - 1)));
        end
        2: begin
          leaf = pick_leaf();
          shuffle_offsets();
          for (int i = 0; i < MASK_BITS; i++) begin
            if ($urandom_range(0, 3) != 0) begin
              send_word(CMD_RELEASE, BLOCK_W'(leaf * MASK_BITS + offsets[i]));
            end
          end
          send_word(CMD_FIND, BLOCK_W'($urandom_range(0, MAX_INDEX)));
        end
        3: begin
          repeat ($urandom_range(1, 4)) begin
            send_word(cmd_t'($urandom_range(0, 3)),
                      BLOCK_W'($urandom_range(NUM_BLOCKS, MAX_INDEX)));
          end
        end
        default: begin
          repeat ($urandom_range(4, 12)) begin
            send_word(cmd_t'($urandom_range(0, 3)), pick_index());
          end
        end
      endcase
    end

    burst = 1'b0;
    repeat (20) begin
      send_word(cmd_t'($urandom_range(0, 3)), pick_index());
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/tlbbt_pkg.sv
src/tlbbt_if.sv
src/tlbbt_ctrl.sv
src/tlbbt_dp.sv
src/two_level_bitmap_block_tracker_core.sv
test/tlbbt_tracker_monitor.sv
test/two_level_bitmap_block_tracker_core_tb.sv
